@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/i2cm_pkg.sv @@
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int BUF_DEPTH = 16;
  localparam int FILL_W = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  // byte position over address byte, two memory address bytes and data
  localparam int BI_W = $clog2(BUF_DEPTH + 4);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  localparam logic [15:0] TPP_RESET = 16'd1;

  // one classified request word as it waits between front and engine
  typedef struct packed {
    logic              tick;
    logic              load;
    logic              start;
    logic              rd;
    logic              sda;
    logic [6:0]        dev_addr;
    logic [15:0]       mem_addr;
    logic [FILL_W-1:0] xfer_len;
    logic [7:0]        wr_byte;
  } cmd_t;

endpackage

@@ rtl/i2cm_front.sv @@
`timescale 1ns / 1ps

module i2cm_front
  import i2cm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 q_valid,
  output cmd_t                 q_cmd,
  input  logic                 q_pop
);

  cmd_t            q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  cmd_t            cmd;
  logic            push;
  logic [4:0]      raw_cnt;

  // decode the request kind and clamp the count to the buffer depth
  always_comb begin
    raw_cnt = in_tdata[28:24];
    cmd = '0;
    cmd.sda = in_tdata[0];
    cmd.dev_addr = in_tdata[7:1];
    cmd.mem_addr = in_tdata[23:8];
    cmd.wr_byte = in_tdata[36:29];
    if (32'(raw_cnt) > BUF_DEPTH) begin
      cmd.xfer_len = FILL_W'(BUF_DEPTH);
    end else begin
      cmd.xfer_len = FILL_W'(raw_cnt);
    end
    case (in_tuser)
      REQ_TICK:  cmd.tick = 1'b1;
      REQ_LOAD:  cmd.load = 1'b1;
      REQ_WRITE: cmd.start = 1'b1;
      REQ_READ: begin
        cmd.start = 1'b1;
        cmd.rd = 1'b1;
      end
      default: cmd.tick = 1'b1;
    endcase
  end

  assign in_tready = (count_r != Q_CW'(Q_DEPTH));
  assign push = in_tvalid && in_tready;
  assign q_valid = (count_r != '0);
  assign q_cmd = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

@@ rtl/i2cm_engine.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_ST_A   = 4'd1;
  localparam logic [3:0] PH_ST_B   = 4'd2;
  localparam logic [3:0] PH_TX_L   = 4'd3;
  localparam logic [3:0] PH_TX_H   = 4'd4;
  localparam logic [3:0] PH_ACK_L  = 4'd5;
  localparam logic [3:0] PH_ACK_H  = 4'd6;
  localparam logic [3:0] PH_RX_L   = 4'd7;
  localparam logic [3:0] PH_RX_H   = 4'd8;
  localparam logic [3:0] PH_MACK_L = 4'd9;
  localparam logic [3:0] PH_MACK_H = 4'd10;
  localparam logic [3:0] PH_SP_A   = 4'd11;
  localparam logic [3:0] PH_SP_B   = 4'd12;

  logic [15:0]           tpp_r;
  logic [3:0]            phase_r, phase_nxt;
  logic [2:0]            bit_index_r, bit_index_nxt;
  logic [BI_W-1:0]       byte_index_r, byte_index_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [7:0]            buf_r [BUF_DEPTH];
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [6:0]            target_r, target_nxt;
  logic [15:0]           maddr_r, maddr_nxt;
  logic [FILL_W-1:0]     len_r, len_nxt;
  logic [15:0]           tick_r, tick_nxt;
  logic                  err_r, err_nxt;
  logic                  rd_r, rd_nxt;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic            step;
  logic            buf_we;
  logic [15:0]     tick_len;
  logic [BI_W-1:0] rd_k;
  logic [BI_W-1:0] buf_off;
  logic [7:0]      tx;
  logic            rx_valid;
  logic            done;
  logic            scl_o;
  logic            sda_o;
  logic [BI_W-1:0] bi_inc;

  assign step = q_valid && (!out_tvalid_r || out_tready);
  assign q_pop = step;
  assign tick_len = (tpp_r == '0) ? 16'd1 : tpp_r;
  assign bi_inc = byte_index_r + 1'b1;

  // next byte to shift out: address byte at start, otherwise the following one
  always_comb begin
    rd_k = (phase_r == PH_ST_B) ? '0 : bi_inc;
    buf_off = rd_k - BI_W'(3);
    if (rd_k == BI_W'(0)) begin
      tx = {target_r, rd_r};
    end else if (rd_k == BI_W'(1)) begin
      tx = maddr_r[15:8];
    end else if (rd_k == BI_W'(2)) begin
      tx = maddr_r[7:0];
    end else if (buf_off < BI_W'(BUF_DEPTH)) begin
      tx = buf_r[buf_off[IDX_W-1:0]];
    end else begin
      tx = 8'h00;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    bit_index_nxt = bit_index_r;
    byte_index_nxt = byte_index_r;
    shift_nxt = shift_r;
    fill_nxt = fill_r;
    target_nxt = target_r;
    maddr_nxt = maddr_r;
    len_nxt = len_r;
    tick_nxt = tick_r;
    err_nxt = err_r;
    rd_nxt = rd_r;
    buf_we = 1'b0;
    rx_valid = 1'b0;
    done = 1'b0;
    if (step) begin
      if (q_cmd.tick) begin
        if (phase_r != PH_IDLE) begin
          if ({1'b0, tick_r} + 17'd1 >= {1'b0, tick_len}) begin
            tick_nxt = '0;
            case (phase_r)
              PH_ST_A: phase_nxt = PH_ST_B;
              PH_ST_B: begin
                byte_index_nxt = '0;
                bit_index_nxt = 3'd7;
                shift_nxt = tx;
                phase_nxt = PH_TX_L;
              end
              PH_TX_L: phase_nxt = PH_TX_H;
              PH_TX_H: begin
                if (bit_index_r == 3'd0) begin
                  phase_nxt = PH_ACK_L;
                end else begin
                  bit_index_nxt = bit_index_r - 1'b1;
                  phase_nxt = PH_TX_L;
                end
              end
              PH_ACK_L: phase_nxt = PH_ACK_H;
              PH_ACK_H: begin
                if (q_cmd.sda) begin
                  err_nxt = 1'b1;
                  phase_nxt = PH_SP_A;
                end else if (rd_r) begin
                  byte_index_nxt = '0;
                  if (len_r == '0) begin
                    phase_nxt = PH_SP_A;
                  end else begin
                    bit_index_nxt = 3'd7;
                    shift_nxt = '0;
                    phase_nxt = PH_RX_L;
                  end
                end else begin
                  byte_index_nxt = bi_inc;
                  if (bi_inc < BI_W'(3) + BI_W'(len_r)) begin
                    bit_index_nxt = 3'd7;
                    shift_nxt = tx;
                    phase_nxt = PH_TX_L;
                  end else begin
                    phase_nxt = PH_SP_A;
                  end
                end
              end
              PH_RX_L: phase_nxt = PH_RX_H;
              PH_RX_H: begin
                shift_nxt = shift_r | (8'(q_cmd.sda) << bit_index_r);
                if (bit_index_r == 3'd0) begin
                  rx_valid = 1'b1;
                  phase_nxt = PH_MACK_L;
                end else begin
                  bit_index_nxt = bit_index_r - 1'b1;
                  phase_nxt = PH_RX_L;
                end
              end
              PH_MACK_L: phase_nxt = PH_MACK_H;
              PH_MACK_H: begin
                byte_index_nxt = bi_inc;
                if (bi_inc < BI_W'(len_r)) begin
                  bit_index_nxt = 3'd7;
                  shift_nxt = '0;
                  phase_nxt = PH_RX_L;
                end else begin
                  phase_nxt = PH_SP_A;
                end
              end
              PH_SP_A: phase_nxt = PH_SP_B;
              PH_SP_B: begin
                phase_nxt = PH_IDLE;
                done = 1'b1;
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
      end else if (phase_r == PH_IDLE) begin
        if (q_cmd.load) begin
          if (fill_r < FILL_W'(BUF_DEPTH)) begin
            buf_we = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end else if (q_cmd.start) begin
          rd_nxt = q_cmd.rd;
          target_nxt = q_cmd.dev_addr;
          maddr_nxt = q_cmd.mem_addr;
          len_nxt = q_cmd.xfer_len;
          if (!q_cmd.rd) begin
            fill_nxt = '0;
          end
          err_nxt = 1'b0;
          byte_index_nxt = '0;
          bit_index_nxt = 3'd7;
          shift_nxt = '0;
          tick_nxt = '0;
          phase_nxt = PH_ST_A;
        end
      end
    end
  end

  // bus levels for the half-phase entered by this word
  always_comb begin
    scl_o = 1'b1;
    sda_o = 1'b1;
    case (phase_nxt)
      PH_ST_A: sda_o = 1'b0;
      PH_ST_B: begin
        scl_o = 1'b0;
        sda_o = 1'b0;
      end
      PH_TX_L: begin
        scl_o = 1'b0;
        sda_o = shift_nxt[bit_index_nxt];
      end
      PH_TX_H: sda_o = shift_nxt[bit_index_nxt];
      PH_ACK_L, PH_RX_L: scl_o = 1'b0;
      PH_ACK_H, PH_RX_H: scl_o = 1'b1;
      PH_MACK_L, PH_MACK_H: begin
        scl_o = (phase_nxt == PH_MACK_H);
        sda_o = ((byte_index_nxt + 1'b1) >= BI_W'(len_nxt));
      end
      PH_SP_A: begin
        scl_o = 1'b0;
        sda_o = 1'b0;
      end
      PH_SP_B: sda_o = 1'b0;
      default: begin
        scl_o = 1'b1;
        sda_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r <= TPP_RESET;
      phase_r <= PH_IDLE;
      bit_index_r <= 3'd7;
      byte_index_r <= '0;
      shift_r <= '0;
      fill_r <= '0;
      target_r <= '0;
      maddr_r <= '0;
      len_r <= '0;
      tick_r <= '0;
      err_r <= 1'b0;
      rd_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tpp_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      bit_index_r <= bit_index_nxt;
      byte_index_r <= byte_index_nxt;
      shift_r <= shift_nxt;
      fill_r <= fill_nxt;
      target_r <= target_nxt;
      maddr_r <= maddr_nxt;
      len_r <= len_nxt;
      tick_r <= tick_nxt;
      err_r <= err_nxt;
      rd_r <= rd_nxt;
      out_tvalid_r <= step || (out_tvalid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[fill_r[IDX_W-1:0]] <= q_cmd.wr_byte;
    end
    if (step) begin
      out_tdata_r <= {2'b00, err_nxt, done, (phase_nxt != PH_IDLE),
                      (rx_valid ? shift_nxt : 8'h00), rx_valid, sda_o, scl_o};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;

  `ASSERT_IMPL(a_tick_bound, phase_r != PH_IDLE, tick_r < tick_len, "tick count past phase length")
  `ASSERT_IMPL(a_tx_range, (phase_r == PH_TX_L) || (phase_r == PH_TX_H), byte_index_r < BI_W'(3) + BI_W'(len_r), "sending past message end")
  `ASSERT_NEXT(a_done_idle, step && done, phase_r == PH_IDLE, "done without return to idle")
  `ASSERT_IMPL(a_rx_valid, step && rx_valid, (phase_r == PH_RX_H) && (bit_index_r == 3'd0), "read byte flagged outside last bit")

endmodule

@@ rtl/i2c_master_mem_write_read.sv @@
`timescale 1ns / 1ps

// i2c master for devices with a 16-bit register address. every input word
// produces exactly one output word. in_tuser carries the request kind: a tick
// advances the bus by one tick (a half-phase lasts ticks_per_phase ticks, 0
// counts as 1), a load pushes a byte into the 16-entry write buffer, and the
// two start kinds begin a write (start, address byte, memory address high then
// low, buffered data, stop) or a read (start, address byte, count bytes in,
// msb first, ack on each but the last, which gets a nack). loads and starts
// are dropped while a transaction runs, and a full buffer drops further loads.
// a slave nack ends the transfer with a stop and status 1 until the next
// start. the block takes one word per clock when the output side keeps
// out_tready high. an accepted word is first written into the request queue;
// the engine works on the head of that queue, and its output register takes
// the result, which then appears on out_tdata. that rate is set by the
// engine's next-state update, which handles one word per clock.
// ticks_per_phase may only be written while no words are in flight.
// there is no clearing pass after reset.

module i2c_master_mem_write_read
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: ticks_per_phase
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // req_type[1:0]
  input  logic [1:0]            in_tuser,
  // sda_in[0], dev_addr[7:1], mem_addr[23:8], byte_count[28:24],
  // write_byte[36:29], zero pad[39:37]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // scl_level[0], sda_level[1], read_valid[2], read_byte[10:3], busy_res[11],
  // done_res[12], status[13], zero pad[15:14]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // classified request words waiting for the engine
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // front: accepts words, decodes the request kind, queues them
  i2cm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // back: bus sequencer, write buffer and output register
  i2cm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
